// ===== rtl/core/min_tracking_stack_assert.svh =====
// Assertion macros for the min tracking stack.
// Each macro takes a label, an antecedent and a consequent; clk and rst_n come
// from the module that uses it.
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

// Consequent holds in the same cycle.
`define MTS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("min_tracking_stack: same-cycle check failed");

// Consequent holds in the following cycle.
`define MTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("min_tracking_stack: next-cycle check failed");

`endif

// ===== rtl/core/mts_pkg.sv =====
`timescale 1ns / 1ps
package mts_pkg;

    localparam int DEF_MAX_DEPTH   = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int OPC_W      = 2;
    localparam int FIELD_W    = 32;
    localparam int CNT_PORT_W = 7;
    localparam int CFG_W      = 7;
    localparam int ERR_W      = 2;

    typedef enum logic [OPC_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_QUERY = 2'd2
    } opcode_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK        = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNDERFLOW = 2'd2,
        ERR_EMPTY     = 2'd3
    } err_t;

    // Controller to datapath
    typedef struct packed {
        logic push_en;
        logic pop_en;
        logic pop_load;
        logic result_en;
        err_t err;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
    } status_t;

endpackage

// ===== rtl/core/mts_ctrl.sv =====
`timescale 1ns / 1ps
module mts_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [mts_pkg::OPC_W-1:0] opcode,
    input  mts_pkg::status_t        status,
    output mts_pkg::cmd_t           cmd,
    output logic                    busy
);
    import mts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd.push_en   = 1'b0;
        cmd.pop_en    = 1'b0;
        cmd.pop_load  = 1'b0;
        cmd.result_en = 1'b0;
        cmd.err       = ERR_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (opcode_t'(opcode))
                        OP_PUSH:
                        begin
                            cmd.result_en = 1'b1;
                            if (status.full)
                            begin
                                cmd.err = ERR_OVERFLOW;
                            end
                            else
                            begin
                                cmd.push_en = 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (status.empty)
                            begin
                                cmd.result_en = 1'b1;
                                cmd.err       = ERR_UNDERFLOW;
                            end
                            else
                            begin
                                // read the entry below the top, report next cycle
                                cmd.pop_en = 1'b1;
                                state_next = S_POP;
                            end
                        end
                        default:
                        begin
                            // query, and the unused code acting as one
                            cmd.result_en = 1'b1;
                            if (status.empty)
                            begin
                                cmd.err = ERR_EMPTY;
                            end
                        end
                    endcase
                end
            end
            S_POP:
            begin
                cmd.pop_load  = 1'b1;
                cmd.result_en = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg == S_POP);

endmodule

// ===== rtl/core/mts_datapath.sv =====
`timescale 1ns / 1ps
module mts_datapath #(
    parameter int MAX_DEPTH   = mts_pkg::DEF_MAX_DEPTH,
    parameter int VALUE_WIDTH = mts_pkg::DEF_VALUE_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mts_pkg::cmd_t                 cmd,
    output mts_pkg::status_t              status,
    input  logic signed [mts_pkg::FIELD_W-1:0] push_value,
    input  logic                          cfg_wr,
    input  logic [mts_pkg::CFG_W-1:0]     cfg_data,
    output logic                          done,
    output logic signed [mts_pkg::FIELD_W-1:0] top_value,
    output logic signed [mts_pkg::FIELD_W-1:0] min_value,
    output logic [mts_pkg::CNT_PORT_W-1:0] entry_count,
    output logic                          is_full,
    output logic                          is_empty,
    output logic [mts_pkg::ERR_W-1:0]     error_code
);
    import mts_pkg::*;

    localparam int CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic [CFG_W-1:0]       depth_reg;
    logic [CNT_W-1:0]       eff_depth;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [VALUE_WIDTH-1:0] top_val_reg;
    logic [VALUE_WIDTH-1:0] top_val_next;
    logic [VALUE_WIDTH-1:0] top_min_reg;
    logic [VALUE_WIDTH-1:0] top_min_next;
    logic [VALUE_WIDTH-1:0] push_ext;
    logic [VALUE_WIDTH-1:0] rd_val_reg;
    logic [VALUE_WIDTH-1:0] rd_min_reg;
    logic [CNT_W-1:0]       rd_cnt;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic signed [63:0]     push_wide;
    logic [63:0]            top_wide;
    logic [63:0]            min_wide;
    logic [31:0]            cnt_wide;
    logic                   done_reg;

    logic [VALUE_WIDTH-1:0] val_mem [MAX_DEPTH];
    logic [VALUE_WIDTH-1:0] min_mem [MAX_DEPTH];

    logic signed [FIELD_W-1:0] top_value_reg;
    logic signed [FIELD_W-1:0] min_value_reg;
    logic [CNT_PORT_W-1:0]     entry_count_reg;
    logic                      is_full_reg;
    logic                      is_empty_reg;
    logic [ERR_W-1:0]          error_code_reg;

    // clamp the configured depth into 1..MAX_DEPTH
    always_comb
    begin
        if (depth_reg == '0)
        begin
            eff_depth = CNT_W'(1);
        end
        else if (32'(depth_reg) > 32'(MAX_DEPTH))
        begin
            eff_depth = CNT_W'(MAX_DEPTH);
        end
        else
        begin
            eff_depth = CNT_W'(depth_reg);
        end
    end

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg >= eff_depth);

    assign push_wide = 64'(push_value);
    assign push_ext  = push_wide[VALUE_WIDTH-1:0];
    assign wr_addr   = count_reg[AW-1:0];
    assign rd_cnt    = count_reg - CNT_W'(2);
    assign rd_addr   = rd_cnt[AW-1:0];

    always_comb
    begin
        count_next   = count_reg;
        top_val_next = top_val_reg;
        top_min_next = top_min_reg;
        if (cmd.push_en)
        begin
            count_next   = count_reg + CNT_W'(1);
            top_val_next = push_ext;
            if (status.empty || ($signed(push_ext) < $signed(top_min_reg)))
            begin
                top_min_next = push_ext;
            end
        end
        if (cmd.pop_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.pop_load)
        begin
            top_val_next = rd_val_reg;
            top_min_next = rd_min_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= CFG_W'(64);
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                depth_reg <= cfg_data;
            end
            count_reg <= count_next;
            done_reg  <= cmd.result_en;
        end
    end

    always_ff @(posedge clk)
    begin
        top_val_reg <= top_val_next;
        top_min_reg <= top_min_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_en)
        begin
            val_mem[wr_addr] <= push_ext;
            min_mem[wr_addr] <= top_min_next;
        end
        if (cmd.pop_en)
        begin
            rd_val_reg <= val_mem[rd_addr];
            rd_min_reg <= min_mem[rd_addr];
        end
    end

    assign top_wide = 64'(top_val_next);
    assign min_wide = 64'(top_min_next);
    assign cnt_wide = 32'(count_next);

    // result reflects the state as it stands after the request
    always_ff @(posedge clk)
    begin
        if (cmd.result_en)
        begin
            if (count_next == '0)
            begin
                top_value_reg <= '0;
                min_value_reg <= '0;
            end
            else
            begin
                top_value_reg <= top_wide[FIELD_W-1:0];
                min_value_reg <= min_wide[FIELD_W-1:0];
            end
            entry_count_reg <= cnt_wide[CNT_PORT_W-1:0];
            is_full_reg     <= (count_next >= eff_depth);
            is_empty_reg    <= (count_next == '0);
            error_code_reg  <= cmd.err;
        end
    end

    assign done        = done_reg;
    assign top_value   = top_value_reg;
    assign min_value   = min_value_reg;
    assign entry_count = entry_count_reg;
    assign is_full     = is_full_reg;
    assign is_empty    = is_empty_reg;
    assign error_code  = error_code_reg;

endmodule

// ===== rtl/core/min_tracking_stack.sv =====
`timescale 1ns / 1ps
// Push, query and refused requests: result strobed the cycle after acceptance,
// next request accepted in that same cycle, so one request per cycle.
// Pop: the entry below the top is read into a register and loaded in S_POP;
// busy is high while in S_POP. The receiver cannot stall results.
// Reset: stack empty, depth register 64; the stores are not cleared.
module min_tracking_stack #(
    parameter int MAX_DEPTH   = mts_pkg::DEF_MAX_DEPTH,
    parameter int VALUE_WIDTH = mts_pkg::DEF_VALUE_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [mts_pkg::OPC_W-1:0]          opcode,
    input  logic signed [mts_pkg::FIELD_W-1:0] push_value,
    output logic                               done,
    output logic signed [mts_pkg::FIELD_W-1:0] top_value,
    output logic signed [mts_pkg::FIELD_W-1:0] min_value,
    output logic [mts_pkg::CNT_PORT_W-1:0]     entry_count,
    output logic                               is_full,
    output logic                               is_empty,
    output logic [mts_pkg::ERR_W-1:0]          error_code,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mts_pkg::CFG_W-1:0]          cfg_data
);
    import mts_pkg::*;

`include "min_tracking_stack_assert.svh"

    cmd_t    cmd;
    status_t status;
    logic    req_go;

    assign cfg_ready = 1'b1;
    assign req_go    = start && !busy;

    mts_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (req_go),
        .opcode (opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    mts_datapath #(
        .MAX_DEPTH   (MAX_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .push_value  (push_value),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .done        (done),
        .top_value   (top_value),
        .min_value   (min_value),
        .entry_count (entry_count),
        .is_full     (is_full),
        .is_empty    (is_empty),
        .error_code  (error_code)
    );

    `MTS_ASSERT_NEXT(a_pop_waits, req_go && (opcode == OP_POP) && !status.empty, busy && !done)
    `MTS_ASSERT_NEXT(a_busy_one_cycle, busy, !busy && done)
    `MTS_ASSERT_SAME(a_empty_zero, done && is_empty, (top_value == '0) && (min_value == '0))
    `MTS_ASSERT_SAME(a_overflow_full, done && (error_code == ERR_OVERFLOW), is_full)

endmodule

// ===== tb/stack_result_checker.sv =====
`timescale 1ns / 1ps
module stack_result_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic [mts_pkg::OPC_W-1:0]          opcode,
    input  logic signed [mts_pkg::FIELD_W-1:0] push_value,
    input  logic                               done,
    input  logic signed [mts_pkg::FIELD_W-1:0] top_value,
    input  logic signed [mts_pkg::FIELD_W-1:0] min_value,
    input  logic [mts_pkg::CNT_PORT_W-1:0]     entry_count,
    input  logic                               is_full,
    input  logic                               is_empty,
    input  logic [mts_pkg::ERR_W-1:0]          error_code,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [mts_pkg::CFG_W-1:0]          cfg_data,
    output int                                 mismatch_count,
    output int                                 pending_count,
    output int                                 checked_count,
    output logic [3:0]                         codes_seen
);
    import mts_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_DEPTH;
    localparam int PRINT_LIMIT = 40;

    typedef struct {
        logic signed [FIELD_W-1:0] top;
        logic signed [FIELD_W-1:0] least;
        logic [CNT_PORT_W-1:0]     count;
        logic                      full;
        logic                      empty;
        err_t                      err;
    } stack_report_t;

    logic signed [FIELD_W-1:0] value_shadow [STORE_DEPTH];
    logic signed [FIELD_W-1:0] least_shadow [STORE_DEPTH];
    int                        held = 0;
    logic [CFG_W-1:0]          depth_reg = CFG_W'(DEF_MAX_DEPTH);
    stack_report_t             awaited_reports [$];
    int                        fails = 0;
    int                        checked = 0;
    int                        printed = 0;
    logic [3:0]                seen = '0;

    // A depth of zero behaves as one, anything past the store size as the store size.
    function automatic int usable_depth();
        if (depth_reg == '0)
            return 1;
        if (int'(depth_reg) > STORE_DEPTH)
            return STORE_DEPTH;
        return int'(depth_reg);
    endfunction

    function automatic stack_report_t apply_request(logic [OPC_W-1:0] op,
                                                    logic signed [FIELD_W-1:0] v);
        stack_report_t             r;
        int                        lim;
        logic signed [FIELD_W-1:0] m;
        lim   = usable_depth();
        r.err = ERR_OK;
        case (op)
            OP_PUSH:
            begin
                if (held >= lim) begin
                    r.err = ERR_OVERFLOW;
                end else begin
                    m = v;
                    // ties keep the older minimum
                    if (held > 0 && !(v < least_shadow[held-1]))
                        m = least_shadow[held-1];
                    value_shadow[held] = v;
                    least_shadow[held] = m;
                    held++;
                end
            end
            OP_POP:
            begin
                if (held == 0)
                    r.err = ERR_UNDERFLOW;
                else
                    held--;
            end
            default:
            begin
                if (held == 0)
                    r.err = ERR_EMPTY;
            end
        endcase
        r.top   = (held > 0) ? value_shadow[held-1] : '0;
        r.least = (held > 0) ? least_shadow[held-1] : '0;
        r.count = CNT_PORT_W'(held);
        r.full  = (held >= lim);
        r.empty = (held == 0);
        return r;
    endfunction

    function automatic void check_field(string name, logic [FIELD_W-1:0] want,
                                        logic [FIELD_W-1:0] got);
        if (got !== want) begin
            fails++;
            if (printed < PRINT_LIMIT) begin
                printed++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        stack_report_t want;
        if (!rst_n) begin
            held      = 0;
            depth_reg = CFG_W'(DEF_MAX_DEPTH);
            awaited_reports.delete();
            mismatch_count <= 0;
            pending_count  <= 0;
            checked_count  <= 0;
            codes_seen     <= '0;
        end else begin
            if (cfg_valid && cfg_ready)
                depth_reg = cfg_data;
            // predict before checking so a same-edge result still finds its entry
            if (start && !busy)
                awaited_reports.push_back(apply_request(opcode, push_value));
            if (done) begin
                if (awaited_reports.size() == 0) begin
                    fails++;
                    if (printed < PRINT_LIMIT) begin
                        printed++;
                        $display("%0t: result with no transaction outstanding", $time);
                    end
                end else begin
                    want = awaited_reports.pop_front();
                    checked++;
                    seen[want.err] = 1'b1;
                    check_field("top_value", want.top, top_value);
                    check_field("min_value", want.least, min_value);
                    check_field("entry_count", FIELD_W'(want.count), FIELD_W'(entry_count));
                    check_field("is_full", FIELD_W'(want.full), FIELD_W'(is_full));
                    check_field("is_empty", FIELD_W'(want.empty), FIELD_W'(is_empty));
                    check_field("error_code", FIELD_W'(want.err), FIELD_W'(error_code));
                end
            end
            mismatch_count <= fails;
            pending_count  <= awaited_reports.size();
            checked_count  <= checked;
            codes_seen     <= seen;
        end
    end

endmodule

// ===== tb/min_tracking_stack_test.sv =====
`timescale 1ns / 1ps
module min_tracking_stack_test;
    import mts_pkg::*;

    // opcode three is decoded as a query
    localparam logic [OPC_W-1:0] OP_QUERY_ALT = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES = 12;
    localparam int ITEMS_PER_PHASE = 150;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [OPC_W-1:0]          opcode;
    logic signed [FIELD_W-1:0] push_value;
    logic                      done;
    logic signed [FIELD_W-1:0] top_value;
    logic signed [FIELD_W-1:0] min_value;
    logic [CNT_PORT_W-1:0]     entry_count;
    logic                      is_full;
    logic                      is_empty;
    logic [ERR_W-1:0]          error_code;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_W-1:0]          cfg_data;

    int                        mismatch_count;
    int                        pending_count;
    int                        checked_count;
    logic [3:0]                codes_seen;

    int                        idle_pct = 0;
    int                        cycle_count = 0;
    logic signed [FIELD_W-1:0] last_pushed = '0;
    int                        pushes = 0;
    int                        pops = 0;
    int                        queries = 0;
    int                        depth_writes = 0;

    int idle_plan [PHASES] = '{0, 70, 37, 0, 70, 37, 0, 70, 37, 70, 0, 37};
    int depth_plan [PHASES] = '{64, 3, 127, 1, 0, 20, 64, 100, 8, 33, 2, 64};

    min_tracking_stack i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .push_value  (push_value),
        .done        (done),
        .top_value   (top_value),
        .min_value   (min_value),
        .entry_count (entry_count),
        .is_full     (is_full),
        .is_empty    (is_empty),
        .error_code  (error_code),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    stack_result_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .push_value     (push_value),
        .done           (done),
        .top_value      (top_value),
        .min_value      (min_value),
        .entry_count    (entry_count),
        .is_full        (is_full),
        .is_empty       (is_empty),
        .error_code     (error_code),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count),
        .codes_seen     (codes_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Hold the request until the block takes it, then maybe go quiet for a while.
    task automatic issue(input logic [OPC_W-1:0] op, input logic signed [FIELD_W-1:0] v);
        start      <= 1'b1;
        opcode     <= op;
        push_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (op == OP_PUSH) begin
            pushes++;
            last_pushed = v;
        end else if (op == OP_POP) begin
            pops++;
        end else begin
            queries++;
        end
        if ($urandom_range(99) < idle_pct) begin
            start      <= 1'b0;
            opcode     <= OPC_W'($urandom);
            push_value <= FIELD_W'($urandom);
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
    endtask

    // Drain every outstanding result; a pop is busy before its result, not after it.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_depth(input logic [CFG_W-1:0] d);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        depth_writes++;
    endtask

    function automatic logic signed [FIELD_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return FIELD_W'($urandom);
        if (sel < 70)
            return FIELD_W'($urandom_range(16) - 8);
        if (sel < 80) begin
            case ($urandom_range(3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        // repeat the last push to hit equal minimums
        return last_pushed;
    endfunction

    function automatic logic [OPC_W-1:0] pick_op(input int push_weight);
        int sel;
        sel = $urandom_range(99);
        if (sel < 12)
            return OP_QUERY;
        if (sel < 16)
            return OP_QUERY_ALT;
        return ($urandom_range(99) < push_weight) ? OP_PUSH : OP_POP;
    endfunction

    // Alternate fill, drain and mixed stretches so full and empty are both reached.
    task automatic run_phase(input int items);
        int remaining;
        int seg;
        int weight;
        remaining = items;
        while (remaining > 0) begin
            seg = $urandom_range(100, 20);
            if (seg > remaining)
                seg = remaining;
            case ($urandom_range(3))
                0:       weight = 90;
                1:       weight = 10;
                2:       weight = 50;
                default: weight = 70;
            endcase
            repeat (seg) issue(pick_op(weight), pick_value());
            remaining -= seg;
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        opcode     <= OP_PUSH;
        push_value <= '0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stack: query, pop and the alternate query encoding all refused
        issue(OP_QUERY, 32'h1234_5678);
        issue(OP_POP, 32'hFFFF_FFFF);
        issue(OP_QUERY_ALT, '0);
        // extremes, a new minimum, an equal minimum, then values above it
        issue(OP_PUSH, 32'h7FFF_FFFF);
        issue(OP_PUSH, 32'h8000_0000);
        issue(OP_PUSH, 32'h8000_0000);
        issue(OP_PUSH, 32'h0000_0000);
        issue(OP_PUSH, 32'hFFFF_FFFF);
        issue(OP_QUERY, 32'hAAAA_5555);
        issue(OP_QUERY_ALT, 32'h5555_AAAA);
        repeat (5) issue(OP_POP, '0);
        issue(OP_POP, '0);

        // depth of one: second push overflows
        write_depth(CFG_W'(1));
        issue(OP_PUSH, 32'sd5);
        issue(OP_PUSH, 32'sd6);
        issue(OP_QUERY, '0);
        issue(OP_POP, '0);
        // depth of zero behaves as one
        write_depth('0);
        issue(OP_PUSH, -32'sd3);
        issue(OP_PUSH, 32'sd4);
        issue(OP_POP, '0);

        depth_plan[9] = $urandom_range(64, 1);
        for (int p = 0; p < PHASES; p++) begin
            write_depth(CFG_W'(depth_plan[p]));
            idle_pct = idle_plan[p];
            run_phase(ITEMS_PER_PHASE);
        end

        idle_pct = 0;
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d pushes, %0d pops, %0d queries across %0d depth writes",
                 pushes, pops, queries, depth_writes);
        $display("%0d results compared; error codes reached (empty,underflow,overflow,ok): %b",
                 checked_count, codes_seen);
        if (mismatch_count == 0 && pending_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
